// ----- rtl/mrtu_pkg.sv -----
// mrtu_pkg: types, codes and the crc-16 byte step shared by the modbus rtu master
// no dependencies

package mrtu_pkg;

  localparam int RX_BUFFER_BYTES = 64;
  localparam int RX_AW = $clog2(RX_BUFFER_BYTES);
  localparam int RX_CW = $clog2(RX_BUFFER_BYTES + 1);

  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [2:0] KIND_TX      = 3'd0;
  localparam logic [2:0] KIND_REFUSE  = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD = 3'd2;
  localparam logic [2:0] KIND_EXCEPT  = 3'd3;
  localparam logic [2:0] KIND_BAD     = 3'd4;

  localparam logic [15:0] CRC_SEED    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [7:0]  EXC_FUNC    = 8'h86;
  localparam logic [15:0] TIMEOUT_RST = 16'd16;

  typedef enum logic [1:0] {
    CMD_SEND,
    CMD_REFUSE,
    CMD_CLOSE
  } cmd_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  slave_addr;
    logic [7:0]  function_code;
    logic [15:0] start_reg;
    logic [15:0] data_word;
    logic [7:0]  rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic [7:0]  payload_byte;
    logic [7:0]  exception_code;
    logic [7:0]  response_function;
    logic        wrong_peer;
    logic [7:0]  query_peer;
    logic [15:0] query_register;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [7:0]       peer;
    logic [7:0]       func;
    logic [15:0]      reg_addr;
    logic [15:0]      data;
    logic [7:0]       q_peer;
    logic [15:0]      q_reg;
    logic [RX_CW-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [RX_AW-1:0] addr;
    logic [7:0]       data;
  } wr_t;

  function automatic logic [15:0] crc_step(logic [15:0] acc_in, logic [7:0] b);
    logic [15:0] acc;
    acc = acc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

endpackage

// ----- rtl/mrtu_front.sv -----
// mrtu_front: accepts input beats, keeps link state, silence count and rx count,
// writes received bytes and queues send, refuse and close commands; uses mrtu_pkg

module mrtu_front import mrtu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_beat_t   in_beat_i,
  input  logic       cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cmd_t       q_cmd_o,
  input  logic       close_done_i,
  output wr_t        wr_o
);

  localparam logic [1:0] LINK_IDLE    = 2'd0;
  localparam logic [1:0] LINK_WAITING = 2'd1;
  localparam logic [1:0] LINK_DATA    = 2'd2;

  logic [1:0]       link_q, link_d;
  logic [15:0]      silence_q, silence_d;
  logic [15:0]      timeout_q;
  logic [RX_CW-1:0] count_q, count_d, cnt_base;
  logic [7:0]       peer_q, peer_d;
  logic [15:0]      reg_q, reg_d;
  logic [1:0]       close_cnt_q, close_cnt_d;
  logic             at_limit, need_q, acc;

  assign at_limit   = !(silence_q < timeout_q);
  assign need_q     = (in_beat_i.opcode == OP_SEND) ||
                      (in_beat_i.opcode == OP_TICK && at_limit && link_q != LINK_IDLE);
  assign in_stall_o = (need_q && q_full_i) ||
                      (in_beat_i.opcode == OP_BYTE && close_cnt_q != 2'd0);
  assign acc        = in_valid_i && !in_stall_o;
  assign cnt_base   = (link_q == LINK_WAITING) ? '0 : count_q;

  always_comb begin
    link_d    = link_q;
    silence_d = silence_q;
    count_d   = count_q;
    peer_d    = peer_q;
    reg_d     = reg_q;
    q_push_o  = 1'b0;
    q_cmd_o   = '{cmd: CMD_CLOSE, peer: in_beat_i.slave_addr,
                  func: in_beat_i.function_code, reg_addr: in_beat_i.start_reg,
                  data: in_beat_i.data_word, q_peer: peer_q, q_reg: reg_q, len: count_q};
    wr_o      = '{en: 1'b0, addr: cnt_base[RX_AW-1:0], data: in_beat_i.rx_byte};
    if (acc) begin
      case (in_beat_i.opcode)
        OP_SEND: begin
          peer_d         = in_beat_i.slave_addr;
          reg_d          = in_beat_i.start_reg;
          q_cmd_o.q_peer = in_beat_i.slave_addr;
          q_cmd_o.q_reg  = in_beat_i.start_reg;
          q_push_o       = 1'b1;
          if (link_q != LINK_IDLE) begin
            q_cmd_o.cmd = CMD_REFUSE;
          end else begin
            q_cmd_o.cmd = CMD_SEND;
            silence_d   = '0;
            link_d      = LINK_WAITING;
            count_d     = '0;
          end
        end
        OP_BYTE: begin
          silence_d = '0;
          count_d   = cnt_base;
          if (link_q == LINK_WAITING) begin
            link_d = LINK_DATA;
          end
          if ((cnt_base + RX_CW'(1)) < RX_CW'(RX_BUFFER_BYTES)) begin
            wr_o.en = 1'b1;
            count_d = cnt_base + RX_CW'(1);
          end
        end
        OP_TICK: begin
          if (!at_limit) begin
            silence_d = silence_q + 16'd1;
          end else if (link_q != LINK_IDLE) begin
            link_d   = LINK_IDLE;
            q_push_o = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    close_cnt_d = close_cnt_q;
    if (q_push_o && q_cmd_o.cmd == CMD_CLOSE) begin
      close_cnt_d = close_cnt_d + 2'd1;
    end
    if (close_done_i) begin
      close_cnt_d = close_cnt_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q      <= LINK_IDLE;
      silence_q   <= '0;
      timeout_q   <= TIMEOUT_RST;
      count_q     <= '0;
      peer_q      <= '0;
      reg_q       <= '0;
      close_cnt_q <= '0;
    end else begin
      link_q      <= link_d;
      silence_q   <= silence_d;
      count_q     <= count_d;
      peer_q      <= peer_d;
      reg_q       <= reg_d;
      close_cnt_q <= close_cnt_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

endmodule

// ----- rtl/mrtu_queue.sv -----
// mrtu_queue: two-entry command queue between front and back
// uses mrtu_pkg

module mrtu_queue import mrtu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign head_o  = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ----- rtl/mrtu_back.sv -----
// mrtu_back: runs queued commands, owns the rx byte memory, checks frame crc
// and drives the registered result beat; uses mrtu_pkg

module mrtu_back import mrtu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  cmd_t      q_head_i,
  output logic      q_pop_o,
  input  wr_t       wr_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o,
  output logic      close_done_o
);

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_SEND   = 3'd1;
  localparam logic [2:0] B_SCAN   = 3'd2;
  localparam logic [2:0] B_DECIDE = 3'd3;
  localparam logic [2:0] B_RD     = 3'd4;
  localparam logic [2:0] B_EMIT   = 3'd5;
  localparam logic [2:0] B_REFUSE = 3'd6;
  localparam logic [2:0] B_SHORT  = 3'd7;

  logic [7:0]       mem [RX_BUFFER_BYTES];
  logic [7:0]       rd_data_q;
  logic [2:0]       st_q, st_d;
  cmd_t             cmd_q, cmd_d;
  logic [RX_CW-1:0] idx_q, idx_d, pidx_q, pidx_d;
  logic             pend_q, pend_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       b0_q, b0_d, b1_q, b1_d, b2_q, b2_d, lo_q, lo_d, hi_q, hi_d;
  logic             ov_q, ov_d;
  out_beat_t        ob_q, ob_d, base;
  logic             can_emit;
  logic [7:0]       tx_b;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[idx_q[RX_AW-1:0]];
  end

  assign can_emit    = !ov_q || !out_stall_i;
  assign q_pop_o     = (st_q == B_IDLE) && !q_empty_i;
  assign out_valid_o = ov_q;
  assign out_beat_o  = ob_q;

  always_comb begin
    base                = '0;
    base.query_peer     = cmd_q.q_peer;
    base.query_register = cmd_q.q_reg;
  end

  always_comb begin
    case (idx_q[2:0])
      3'd0:    tx_b = cmd_q.peer;
      3'd1:    tx_b = cmd_q.func;
      3'd2:    tx_b = cmd_q.reg_addr[15:8];
      3'd3:    tx_b = cmd_q.reg_addr[7:0];
      3'd4:    tx_b = cmd_q.data[15:8];
      3'd5:    tx_b = cmd_q.data[7:0];
      3'd6:    tx_b = crc_q[7:0];
      default: tx_b = crc_q[15:8];
    endcase
  end

  always_comb begin
    st_d         = st_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    pidx_d       = pidx_q;
    pend_d       = 1'b0;
    crc_d        = crc_q;
    b0_d         = b0_q;
    b1_d         = b1_q;
    b2_d         = b2_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    ov_d         = ov_q && out_stall_i;
    ob_d         = ob_q;
    close_done_o = 1'b0;
    unique case (st_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          cmd_d = q_head_i;
          idx_d = '0;
          crc_d = CRC_SEED;
          case (q_head_i.cmd)
            CMD_SEND:   st_d = B_SEND;
            CMD_REFUSE: st_d = B_REFUSE;
            default:    st_d = (q_head_i.len <= RX_CW'(4)) ? B_SHORT : B_SCAN;
          endcase
        end
      end
      B_SEND: begin
        if (can_emit) begin
          ov_d         = 1'b1;
          ob_d         = base;
          ob_d.kind    = KIND_TX;
          ob_d.tx_byte = tx_b;
          ob_d.last    = idx_q[2:0] == 3'd7;
          if (idx_q[2:0] < 3'd6) begin
            crc_d = crc_step(crc_q, tx_b);
          end
          idx_d = idx_q + RX_CW'(1);
          if (idx_q[2:0] == 3'd7) begin
            st_d = B_IDLE;
          end
        end
      end
      B_REFUSE: begin
        if (can_emit) begin
          ov_d      = 1'b1;
          ob_d      = base;
          ob_d.kind = KIND_REFUSE;
          ob_d.last = 1'b1;
          st_d      = B_IDLE;
        end
      end
      B_SHORT: begin
        if (can_emit) begin
          ov_d         = 1'b1;
          ob_d         = base;
          ob_d.kind    = KIND_BAD;
          ob_d.last    = 1'b1;
          close_done_o = 1'b1;
          st_d         = B_IDLE;
        end
      end
      B_SCAN: begin
        if (idx_q < cmd_q.len) begin
          pend_d = 1'b1;
          pidx_d = idx_q;
          idx_d  = idx_q + RX_CW'(1);
        end
        if (pend_q) begin
          if (pidx_q < cmd_q.len - RX_CW'(2)) begin
            crc_d = crc_step(crc_q, rd_data_q);
          end
          if (pidx_q == RX_CW'(0)) begin
            b0_d = rd_data_q;
          end
          if (pidx_q == RX_CW'(1)) begin
            b1_d = rd_data_q;
          end
          if (pidx_q == RX_CW'(2)) begin
            b2_d = rd_data_q;
          end
          if (pidx_q == cmd_q.len - RX_CW'(2)) begin
            lo_d = rd_data_q;
          end
          if (pidx_q == cmd_q.len - RX_CW'(1)) begin
            hi_d   = rd_data_q;
            pend_d = 1'b0;
            st_d   = B_DECIDE;
          end
        end
      end
      B_DECIDE: begin
        if (crc_q != {hi_q, lo_q}) begin
          if (can_emit) begin
            ov_d         = 1'b1;
            ob_d         = base;
            ob_d.kind    = KIND_BAD;
            ob_d.last    = 1'b1;
            close_done_o = 1'b1;
            st_d         = B_IDLE;
          end
        end else if (b1_q == EXC_FUNC) begin
          if (can_emit) begin
            ov_d                   = 1'b1;
            ob_d                   = base;
            ob_d.kind              = KIND_EXCEPT;
            ob_d.exception_code    = b2_q;
            ob_d.response_function = b1_q;
            ob_d.wrong_peer        = b0_q != cmd_q.q_peer;
            ob_d.last              = 1'b1;
            close_done_o           = 1'b1;
            st_d                   = B_IDLE;
          end
        end else begin
          idx_d = RX_CW'(2);
          st_d  = B_RD;
        end
      end
      B_RD: begin
        st_d = B_EMIT;
      end
      B_EMIT: begin
        if (can_emit) begin
          ov_d                   = 1'b1;
          ob_d                   = base;
          ob_d.kind              = KIND_PAYLOAD;
          ob_d.payload_byte      = rd_data_q;
          ob_d.response_function = b1_q;
          ob_d.wrong_peer        = b0_q != cmd_q.q_peer;
          ob_d.last              = idx_q == cmd_q.len - RX_CW'(3);
          if (idx_q == cmd_q.len - RX_CW'(3)) begin
            close_done_o = 1'b1;
            st_d         = B_IDLE;
          end else begin
            idx_d = idx_q + RX_CW'(1);
            st_d  = B_RD;
          end
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pidx_q <= pidx_d;
    crc_q  <= crc_d;
    b0_q   <= b0_d;
    b1_q   <= b1_d;
    b2_q   <= b2_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    ob_q   <= ob_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= B_IDLE;
      idx_q  <= '0;
      pend_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      idx_q  <= idx_d;
      pend_q <= pend_d;
      ov_q   <= ov_d;
    end
  end

endmodule

// ----- rtl/modbus_rtu_master_transaction.sv -----
// modbus rtu master: the front takes byte, tick and config beats; a send gives 8 tx beats
// one per cycle while the output does not stall; a frame close reads the rx memory one byte
// a cycle, then gives each payload beat from a B_RD read state and a B_EMIT state
// a two-entry command queue lets the front take beats while the back works
// reset clears all control state, timeout_ticks returns to 16; rx memory stays undefined
// depends on mrtu_pkg, mrtu_front, mrtu_queue, mrtu_back

module modbus_rtu_master_transaction import mrtu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_beat_t    in_beat_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_beat_t   out_beat_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i
);

  logic q_full, q_empty, q_push, q_pop, close_done;
  cmd_t q_cmd, q_head;
  wr_t  wr;

  mrtu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_beat_i    (in_beat_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_cmd),
    .close_done_i (close_done),
    .wr_o         (wr)
  );

  mrtu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mrtu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .wr_i         (wr),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_beat_o   (out_beat_o),
    .close_done_o (close_done)
  );

endmodule

// ----- rtl/mrtu_checker.sv -----
// mrtu_checker: port-level assertions for the modbus rtu master, bound to the top level
// uses mrtu_pkg

module mrtu_checker import mrtu_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_beat_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("result beat changed while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_beat_o.kind <= KIND_BAD)
    else $error("result kind out of range");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.kind == KIND_REFUSE || out_beat_o.kind == KIND_EXCEPT ||
                    out_beat_o.kind == KIND_BAD) |-> out_beat_o.last)
    else $error("single-beat result without last");

  a_tx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.kind == KIND_TX |->
      out_beat_o.payload_byte == 8'd0 && out_beat_o.exception_code == 8'd0 &&
      out_beat_o.response_function == 8'd0 && !out_beat_o.wrong_peer)
    else $error("tx beat carries response fields");

endmodule

bind modbus_rtu_master_transaction mrtu_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);

// ----- tb/tb.sv -----
// tb: self-checking testbench for modbus_rtu_master_transaction
// a scoreboard class predicts every result beat from the accepted input beats
// depends on mrtu_pkg and the rtl of modbus_rtu_master_transaction
`timescale 1ns / 1ps

module tb;
  import mrtu_pkg::*;

  typedef enum logic [1:0] {
    LINK_IDLE,
    LINK_WAITING,
    LINK_DATA
  } link_e;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int DRAIN_CYCLES = 300;

  class mrtu_scoreboard;
    logic [15:0] timeout_ticks;
    link_e       link;
    logic [15:0] silence;
    logic [7:0]  rx_mem [RX_BUFFER_BYTES];
    int          rx_len;
    logic [7:0]  q_peer;
    logic [15:0] q_reg;
    out_beat_t   pending_q [$];
    int          errors;

    function new();
      timeout_ticks = TIMEOUT_RST;
      link = LINK_IDLE;
      silence = '0;
      rx_len = 0;
      q_peer = '0;
      q_reg = '0;
      errors = 0;
    endfunction

    function logic [15:0] crc_add(logic [15:0] acc_in, logic [7:0] b);
      logic [15:0] acc;
      acc = acc_in ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
        acc = acc[0] ? ((acc >> 1) ^ 16'hA001) : (acc >> 1);
      end
      return acc;
    endfunction

    function void push(logic [2:0] kind, logic [7:0] txb, logic [7:0] pay,
                       logic [7:0] exc, logic [7:0] func, logic wrong, logic lst);
      out_beat_t e;
      e.kind = kind;
      e.tx_byte = txb;
      e.payload_byte = pay;
      e.exception_code = exc;
      e.response_function = func;
      e.wrong_peer = wrong;
      e.query_peer = q_peer;
      e.query_register = q_reg;
      e.last = lst;
      pending_q.push_back(e);
    endfunction

    function void close_frame();
      logic [15:0] crc;
      logic [15:0] got;
      logic [7:0]  func;
      logic        wrong;
      if (rx_len <= 4) begin
        push(KIND_BAD, '0, '0, '0, '0, 1'b0, 1'b1);
        return;
      end
      crc = CRC_SEED;
      for (int i = 0; i < rx_len - 2; i++) crc = crc_add(crc, rx_mem[i]);
      got = {rx_mem[rx_len-1], rx_mem[rx_len-2]};
      if (crc != got) begin
        push(KIND_BAD, '0, '0, '0, '0, 1'b0, 1'b1);
        return;
      end
      func = rx_mem[1];
      wrong = (rx_mem[0] != q_peer);
      if (func == EXC_FUNC) begin
        push(KIND_EXCEPT, '0, '0, rx_mem[2], func, wrong, 1'b1);
      end else begin
        for (int i = 2; i + 2 < rx_len; i++)
          push(KIND_PAYLOAD, '0, rx_mem[i], '0, func, wrong, i + 3 == rx_len);
      end
    endfunction

    function void note_input(in_beat_t b);
      logic [7:0]  fr [8];
      logic [15:0] crc;
      case (b.opcode)
        OP_SEND: begin
          q_peer = b.slave_addr;
          q_reg = b.start_reg;
          if (link != LINK_IDLE) begin
            push(KIND_REFUSE, '0, '0, '0, '0, 1'b0, 1'b1);
          end else begin
            silence = '0;
            link = LINK_WAITING;
            rx_len = 0;
            fr[0] = b.slave_addr;
            fr[1] = b.function_code;
            fr[2] = b.start_reg[15:8];
            fr[3] = b.start_reg[7:0];
            fr[4] = b.data_word[15:8];
            fr[5] = b.data_word[7:0];
            crc = CRC_SEED;
            for (int i = 0; i < 6; i++) crc = crc_add(crc, fr[i]);
            fr[6] = crc[7:0];
            fr[7] = crc[15:8];
            for (int i = 0; i < 8; i++) push(KIND_TX, fr[i], '0, '0, '0, 1'b0, i == 7);
          end
        end
        OP_BYTE: begin
          silence = '0;
          if (link == LINK_WAITING) begin
            rx_len = 0;
            link = LINK_DATA;
          end
          if (rx_len + 1 < RX_BUFFER_BYTES) begin
            rx_mem[rx_len] = b.rx_byte;
            rx_len++;
          end
        end
        OP_TICK: begin
          if (silence < timeout_ticks) begin
            silence++;
          end else if (link != LINK_IDLE) begin
            link = LINK_IDLE;
            close_frame();
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_beat_t a);
      out_beat_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $realtime, a);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (a.kind !== e.kind || a.tx_byte !== e.tx_byte ||
          a.payload_byte !== e.payload_byte || a.exception_code !== e.exception_code ||
          a.response_function !== e.response_function || a.wrong_peer !== e.wrong_peer ||
          a.query_peer !== e.query_peer || a.query_register !== e.query_register ||
          a.last !== e.last) begin
        $display("%0t: mismatch, expected %h actual %h", $realtime, e, a);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_beat_t    in_beat_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_beat_t   out_beat_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  mrtu_scoreboard sb = new();
  bit quiet = 1'b0;

  modbus_rtu_master_transaction dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_beat_i(in_beat_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_beat_o(out_beat_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stall per beat outside the quiet phase, check on every accepted beat
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_beat_o);
    end
  end

  function automatic in_beat_t rand_beat(logic [1:0] op);
    in_beat_t b;
    b.opcode = op;
    b.slave_addr = 8'($urandom);
    b.function_code = 8'($urandom);
    b.start_reg = 16'($urandom);
    b.data_word = 16'($urandom);
    b.rx_byte = 8'($urandom);
    return b;
  endfunction

  task automatic drive_beat(in_beat_t b);
    int n;
    n = quiet ? 0 : $urandom_range(0, 9);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(b);
  endtask

  task automatic drive_send(logic [7:0] peer, logic [15:0] regv, logic [15:0] data);
    in_beat_t b;
    b = rand_beat(OP_SEND);
    b.slave_addr = peer;
    b.start_reg = regv;
    b.data_word = data;
    drive_beat(b);
  endtask

  task automatic drive_rx(logic [7:0] v);
    in_beat_t b;
    b = rand_beat(OP_BYTE);
    b.rx_byte = v;
    drive_beat(b);
  endtask

  task automatic drive_ticks(int n);
    for (int i = 0; i < n; i++) drive_beat(rand_beat(OP_TICK));
  endtask

  // one response frame, then enough ticks to close it
  task automatic reply(int len, bit exc, bit own_peer, bit good_crc);
    logic [7:0]  fr [$];
    logic [15:0] crc;
    logic [7:0]  func;
    fr.push_back(own_peer ? sb.q_peer : 8'($urandom));
    func = 8'($urandom);
    if (func == EXC_FUNC) func = 8'h03;
    fr.push_back(exc ? EXC_FUNC : func);
    while (fr.size() < len - 2) fr.push_back(8'($urandom));
    crc = CRC_SEED;
    foreach (fr[i]) crc = sb.crc_add(crc, fr[i]);
    if (!good_crc) crc ^= 16'(1 << $urandom_range(0, 15));
    fr.push_back(crc[7:0]);
    fr.push_back(crc[15:8]);
    foreach (fr[i]) drive_rx(fr[i]);
    drive_ticks(sb.timeout_ticks + 1);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] v);
    settle();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.timeout_ticks = v;
  endtask

  task automatic transaction();
    int r;
    drive_send(8'($urandom), 16'($urandom), 16'($urandom));
    r = $urandom_range(0, 19);
    if (r == 0) drive_send(8'($urandom), 16'($urandom), 16'($urandom));
    if (r < 13) reply($urandom_range(5, 10), 1'b0, $urandom_range(0, 3) != 0, 1'b1);
    else if (r < 15) reply($urandom_range(5, 8), 1'b1, 1'b1, 1'b1);
    else if (r < 17) reply($urandom_range(5, 9), 1'b0, 1'b1, 1'b0);
    else if (r < 18) reply($urandom_range(3, 4), 1'b0, 1'b1, 1'b1);
    else begin
      repeat ($urandom_range(0, 3)) drive_beat(rand_beat(2'($urandom)));
      drive_ticks(sb.timeout_ticks + 1);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset timeout
    drive_ticks(20);
    drive_beat(rand_beat(OP_NONE));
    drive_rx(8'hFF);
    drive_send(8'h00, 16'h0000, 16'h0000);
    drive_send(8'hFF, 16'hFFFF, 16'hFFFF);
    reply(8, 1'b0, 1'b1, 1'b1);
    drive_send(8'hFF, 16'hFFFF, 16'hFFFF);
    reply(5, 1'b1, 1'b0, 1'b1);

    write_timeout(16'd0);
    drive_send(8'h11, 16'h1234, 16'h00FF);
    reply(4, 1'b0, 1'b1, 1'b1);
    drive_send(8'h5A, 16'h8000, 16'h7FFF);
    reply(7, 1'b0, 1'b1, 1'b0);
    drive_send(8'h01, 16'h0001, 16'h0001);
    repeat (70) drive_rx(8'($urandom));
    drive_ticks(1);

    write_timeout(16'hFFFF);
    drive_send(8'h22, 16'h0F0F, 16'hF0F0);
    repeat (4) drive_rx(8'($urandom));
    drive_ticks(3);
    drive_send(8'h33, 16'hAAAA, 16'h5555);

    write_timeout(16'd1);
    drive_ticks(2);

    // random part over several timeout settings
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_timeout(ph == 5 ? 16'd0 : 16'($urandom_range(0, 4)));
      quiet = (ph == 2);
      repeat (4) begin
        transaction();
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- modbus_rtu_master_transaction.f -----
rtl/mrtu_pkg.sv
rtl/mrtu_front.sv
rtl/mrtu_queue.sv
rtl/mrtu_back.sv
rtl/modbus_rtu_master_transaction.sv
rtl/mrtu_checker.sv
tb/tb.sv
